@@ rtl/srpf_pkg.sv @@
// Shared types, constants and arithmetic helpers of the shape record path flattener.
// Used by the channel interfaces and by every RTL module; depends on nothing.
package srpf_pkg;

  // Position word width inside the block (positions wrap at this width)
  localparam int COORD_BITS = 24;

  // Fixed field widths of the record and point channels
  localparam int FIELD_W = 24;
  localparam int STYLE_W = 8;
  localparam int CMD_W   = 2;
  localparam int KIND_W  = 2;

  // Curve flattening: subdivision depth, sub-pixel scale and rounding bias
  localparam int SUBDIV_DEPTH  = 3;
  localparam int NLEAF         = 1 << (SUBDIV_DEPTH - 1);
  localparam int SUBDIV_STAGES = 2 * SUBDIV_DEPTH;
  localparam int SCALE_SH      = 8;
  localparam int RND_BIAS      = 1 << (SCALE_SH - 1);
  localparam int SC_W          = COORD_BITS + SCALE_SH;

  // Result slots of one record, in emission order
  localparam int SLOT_RESTYLE = 0;
  localparam int SLOT_START   = 1;
  localparam int SLOT_LEAF0   = 2;
  localparam int SLOT_END     = SLOT_LEAF0 + NLEAF;
  localparam int NSLOT        = SLOT_END + 1;
  localparam int SLOT_W       = $clog2(NSLOT);
  localparam int LEAF_W       = $clog2(NLEAF);

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_STYLE = 2'd0,
    CMD_LINE  = 2'd1,
    CMD_CURVE = 2'd2
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_START   = 2'd0,
    KIND_NEXT    = 2'd1,
    KIND_RESTYLE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_LINE  = 2'd1,
    OP_CURVE = 2'd2
  } op_e;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [FIELD_W-1:0]    field_t;
  typedef logic        [STYLE_W-1:0]    style_t;
  typedef logic signed [SC_W-1:0]       sc_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } cpt_t;

  typedef struct packed {
    sc_t x;
    sc_t y;
  } spt_t;

  // One classified record: which results it owes and the points behind them
  typedef struct packed {
    logic   restyle;
    logic   start;
    op_e    op;
    cpt_t   rest_pt;
    cpt_t   start_pt;
    cpt_t   base_pt;
    cpt_t   ctl_pt;
    cpt_t   end_pt;
    style_t fill0;
    style_t fill1;
    style_t line;
  } job_t;

  typedef struct packed {
    kind_e  kind;
    field_t x;
    field_t y;
    style_t fill0;
    style_t fill1;
    style_t line;
    logic   last;
  } res_t;

  function automatic coord_t from_field(field_t v);
    return coord_t'(v);
  endfunction

  function automatic field_t to_field(coord_t v);
    return field_t'(unsigned'(v));
  endfunction

  function automatic spt_t scale_pt(cpt_t p);
    spt_t r;
    r.x = {p.x, {SCALE_SH{1'b0}}};
    r.y = {p.y, {SCALE_SH{1'b0}}};
    return r;
  endfunction

  // (a + b) / 2, truncated toward zero
  function automatic sc_t half_sum(sc_t a, sc_t b);
    logic signed [SC_W:0] s;
    s = {a[SC_W-1], a} + {b[SC_W-1], b};
    s = s + {{SC_W{1'b0}}, s[SC_W]};
    return s[SC_W:1];
  endfunction

  function automatic spt_t mid(spt_t a, spt_t b);
    spt_t r;
    r.x = half_sum(a.x, b.x);
    r.y = half_sum(a.y, b.y);
    return r;
  endfunction

  // Round a sub-pixel value to the nearest position, halves upwards, and wrap
  function automatic coord_t round_leaf(sc_t v);
    sc_t t;
    t = v + sc_t'(RND_BIAS);
    return t[SC_W-1:SCALE_SH];
  endfunction

endpackage

@@ rtl/srpf_if.sv @@
// Valid/ready channel interfaces: shape records in, path points out.
// Depends on srpf_pkg for the field widths.
interface srpf_rec_if;
  import srpf_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          cmd;
  logic                      set_fill0;
  logic                      set_fill1;
  logic                      set_line;
  logic                      move_to;
  logic [STYLE_W-1:0]        fill0_index;
  logic [STYLE_W-1:0]        fill1_index;
  logic [STYLE_W-1:0]        line_index;
  logic signed [FIELD_W-1:0] coord_x;
  logic signed [FIELD_W-1:0] coord_y;
  logic signed [FIELD_W-1:0] anchor_dx;
  logic signed [FIELD_W-1:0] anchor_dy;

  modport source (
    output valid, cmd, set_fill0, set_fill1, set_line, move_to,
           fill0_index, fill1_index, line_index, coord_x, coord_y, anchor_dx, anchor_dy,
    input  ready
  );

  modport sink (
    input  valid, cmd, set_fill0, set_fill1, set_line, move_to,
           fill0_index, fill1_index, line_index, coord_x, coord_y, anchor_dx, anchor_dy,
    output ready
  );
endinterface

interface srpf_pt_if;
  import srpf_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic signed [FIELD_W-1:0] point_x;
  logic signed [FIELD_W-1:0] point_y;
  logic [STYLE_W-1:0]        fill0_style;
  logic [STYLE_W-1:0]        fill1_style;
  logic [STYLE_W-1:0]        line_style;
  logic                      last;

  modport source (
    output valid, kind, point_x, point_y, fill0_style, fill1_style, line_style, last,
    input  ready
  );

  modport sink (
    input  valid, kind, point_x, point_y, fill0_style, fill1_style, line_style, last,
    output ready
  );
endinterface

@@ rtl/srpf_front.sv @@
// Front end: takes records, tracks pen, styles and open path, and classifies each
// record into a job for the queue. Depends on srpf_pkg and srpf_rec_if.
module srpf_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  srpf_rec_if.sink        rec_i,
  input  logic            q_ready_i,
  output logic            q_push_o,
  output srpf_pkg::job_t  q_job_o
);
  import srpf_pkg::*;

  cpt_t   pen_q, pen_d;
  style_t fill0_q, fill0_d, fill1_q, fill1_d, line_q, line_d;
  logic   open_q, open_d;
  logic   accept, any_set;
  cpt_t   base, ctl, endp, delta;
  job_t   job;

  assign rec_i.ready = q_ready_i;
  assign accept      = rec_i.valid && rec_i.ready;

  always_comb begin
    delta.x = from_field(rec_i.coord_x);
    delta.y = from_field(rec_i.coord_y);
    // an edge with no open path starts from the origin
    base.x  = open_q ? pen_q.x : '0;
    base.y  = open_q ? pen_q.y : '0;
    ctl.x   = base.x + delta.x;
    ctl.y   = base.y + delta.y;
    endp.x  = ctl.x + from_field(rec_i.anchor_dx);
    endp.y  = ctl.y + from_field(rec_i.anchor_dy);
    any_set = rec_i.set_fill0 || rec_i.set_fill1 || rec_i.set_line;

    pen_d   = pen_q;
    open_d  = open_q;
    fill0_d = fill0_q;
    fill1_d = fill1_q;
    line_d  = line_q;
    job     = '0;
    job.op  = OP_NONE;
    job.rest_pt = pen_q;
    job.base_pt = base;
    job.ctl_pt  = ctl;

    case (rec_i.cmd)
      CMD_STYLE: begin
        if (rec_i.set_fill0) fill0_d = rec_i.fill0_index;
        if (rec_i.set_fill1) fill1_d = rec_i.fill1_index;
        if (rec_i.set_line)  line_d  = rec_i.line_index;
        job.restyle  = any_set && open_q;
        job.start    = rec_i.move_to;
        job.start_pt = delta;
        if (rec_i.move_to) begin
          pen_d  = delta;
          open_d = 1'b1;
        end
      end
      CMD_LINE: begin
        job.start    = !open_q;
        job.op       = OP_LINE;
        job.end_pt   = ctl;
        pen_d        = ctl;
        open_d       = 1'b1;
      end
      CMD_CURVE: begin
        job.start    = !open_q;
        job.op       = OP_CURVE;
        job.end_pt   = endp;
        pen_d        = endp;
        open_d       = 1'b1;
      end
      default: begin
      end
    endcase

    job.fill0 = fill0_d;
    job.fill1 = fill1_d;
    job.line  = line_d;
  end

  // drop records that owe no result
  assign q_push_o = accept && (job.restyle || job.start || job.op != OP_NONE);
  assign q_job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_q   <= '0;
      open_q  <= 1'b0;
      fill0_q <= '0;
      fill1_q <= '0;
      line_q  <= '0;
    end else if (accept) begin
      pen_q   <= pen_d;
      open_q  <= open_d;
      fill0_q <= fill0_d;
      fill1_q <= fill1_d;
      line_q  <= line_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (rec_i.cmd == CMD_LINE || rec_i.cmd == CMD_CURVE)) |=> open_q)
    else $error("path not open after an edge record");

endmodule

@@ rtl/srpf_fifo.sv @@
// Short job queue between the front end and the back end.
// Depends on srpf_pkg for the job type and depth.
module srpf_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  srpf_pkg::job_t  data_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            valid_o,
  output srpf_pkg::job_t  data_o
);
  import srpf_pkg::*;

  job_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_pop;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || do_pop))
    else $error("job queue overrun");

endmodule

@@ rtl/srpf_subdiv.sv @@
// Pipelined midpoint subdivision of quadratic curves, one level of halvings after another;
// carries every job alongside. Depends on srpf_pkg.
module srpf_subdiv (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               adv_i,
  input  logic                               vld_i,
  input  srpf_pkg::job_t                     job_i,
  output logic                               vld_o,
  output srpf_pkg::job_t                     job_o,
  output srpf_pkg::spt_t [srpf_pkg::NLEAF-1:0] leaf_o
);
  import srpf_pkg::*;

  logic [SUBDIV_STAGES-1:0] vld_q;
  job_t                     job_q [SUBDIV_STAGES];

  spt_t a_in, c_in, b_in;
  spt_t s1_a_q, s1_c1_q, s1_c2_q, s1_b_q;
  spt_t s2_a_q, s2_c1_q, s2_m_q, s2_c2_q, s2_b_q;
  spt_t s3_a_q, s3_d1_q, s3_d2_q, s3_m_q, s3_g1_q, s3_g2_q, s3_b_q;
  spt_t s4_a_q, s4_d1_q, s4_m2_q, s4_d2_q, s4_m_q, s4_g1_q, s4_m3_q, s4_g2_q, s4_b_q;
  spt_t s5_e1_q, s5_e2_q, s5_f1_q, s5_f2_q, s5_h1_q, s5_h2_q, s5_k1_q, s5_k2_q;
  spt_t [NLEAF-1:0] leaf_q;

  assign a_in = scale_pt(job_i.base_pt);
  assign c_in = scale_pt(job_i.ctl_pt);
  assign b_in = scale_pt(job_i.end_pt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[SUBDIV_STAGES-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      job_q[0] <= job_i;
      for (int i = 1; i < SUBDIV_STAGES; i++) begin
        job_q[i] <= job_q[i-1];
      end
      // first level: split the hull
      s1_a_q  <= a_in;
      s1_c1_q <= mid(a_in, c_in);
      s1_c2_q <= mid(b_in, c_in);
      s1_b_q  <= b_in;
      s2_a_q  <= s1_a_q;
      s2_c1_q <= s1_c1_q;
      s2_m_q  <= mid(s1_c1_q, s1_c2_q);
      s2_c2_q <= s1_c2_q;
      s2_b_q  <= s1_b_q;
      // second level: both halves
      s3_a_q  <= s2_a_q;
      s3_d1_q <= mid(s2_a_q, s2_c1_q);
      s3_d2_q <= mid(s2_m_q, s2_c1_q);
      s3_m_q  <= s2_m_q;
      s3_g1_q <= mid(s2_m_q, s2_c2_q);
      s3_g2_q <= mid(s2_b_q, s2_c2_q);
      s3_b_q  <= s2_b_q;
      s4_a_q  <= s3_a_q;
      s4_d1_q <= s3_d1_q;
      s4_m2_q <= mid(s3_d1_q, s3_d2_q);
      s4_d2_q <= s3_d2_q;
      s4_m_q  <= s3_m_q;
      s4_g1_q <= s3_g1_q;
      s4_m3_q <= mid(s3_g1_q, s3_g2_q);
      s4_g2_q <= s3_g2_q;
      s4_b_q  <= s3_b_q;
      // third level: four quarters
      s5_e1_q <= mid(s4_a_q, s4_d1_q);
      s5_e2_q <= mid(s4_m2_q, s4_d1_q);
      s5_f1_q <= mid(s4_m2_q, s4_d2_q);
      s5_f2_q <= mid(s4_m_q, s4_d2_q);
      s5_h1_q <= mid(s4_m_q, s4_g1_q);
      s5_h2_q <= mid(s4_m3_q, s4_g1_q);
      s5_k1_q <= mid(s4_m3_q, s4_g2_q);
      s5_k2_q <= mid(s4_b_q, s4_g2_q);
      leaf_q[0] <= mid(s5_e1_q, s5_e2_q);
      leaf_q[1] <= mid(s5_f1_q, s5_f2_q);
      leaf_q[2] <= mid(s5_h1_q, s5_h2_q);
      leaf_q[3] <= mid(s5_k1_q, s5_k2_q);
    end
  end

  assign vld_o  = vld_q[SUBDIV_STAGES-1];
  assign job_o  = job_q[SUBDIV_STAGES-1];
  assign leaf_o = leaf_q;

endmodule

@@ rtl/srpf_emit.sv @@
// Back end emitter: walks the result slots of the job at the end of the pipeline
// and drives the registered point channel. Depends on srpf_pkg and srpf_pt_if.
module srpf_emit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 vld_i,
  input  srpf_pkg::job_t                       job_i,
  input  srpf_pkg::spt_t [srpf_pkg::NLEAF-1:0] leaf_i,
  output logic                                 adv_o,
  srpf_pt_if.source                            pt_o
);
  import srpf_pkg::*;

  logic [NSLOT-1:0]  slots, pend, pick_oh, done_q, done_d;
  logic [SLOT_W-1:0] sel;
  logic              last, out_free, go;
  logic              out_vld_q, out_vld_d;
  res_t              out_q, out_d;
  cpt_t              pt;
  kind_e             kind;
  spt_t              leaf;

  // pick the earliest slot still owed
  always_comb begin
    slots                        = '0;
    slots[SLOT_RESTYLE]          = job_i.restyle;
    slots[SLOT_START]            = job_i.start;
    slots[SLOT_LEAF0 +: NLEAF]   = {NLEAF{job_i.op == OP_CURVE}};
    slots[SLOT_END]              = (job_i.op != OP_NONE);
    pend                         = slots & ~done_q;
    sel                          = SLOT_W'(SLOT_END);
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (pend[i]) begin
        sel = SLOT_W'(i);
      end
    end
    pick_oh = NSLOT'(1) << sel;
    last    = ((pend & ~pick_oh) == '0);
  end

  assign out_free = !out_vld_q || pt_o.ready;
  assign go       = vld_i && out_free;
  assign adv_o    = !vld_i || (go && last);

  always_comb begin
    leaf = leaf_i[LEAF_W'(sel - SLOT_W'(SLOT_LEAF0))];
    case (sel) inside
      SLOT_W'(SLOT_RESTYLE): begin
        kind = KIND_RESTYLE;
        pt   = job_i.rest_pt;
      end
      SLOT_W'(SLOT_START): begin
        kind = KIND_START;
        pt   = job_i.start_pt;
      end
      [SLOT_W'(SLOT_LEAF0):SLOT_W'(SLOT_END - 1)]: begin
        kind = KIND_NEXT;
        pt.x = round_leaf(leaf.x);
        pt.y = round_leaf(leaf.y);
      end
      SLOT_W'(SLOT_END): begin
        kind = KIND_NEXT;
        pt   = job_i.end_pt;
      end
      default: begin
        kind = KIND_NEXT;
        pt   = '0;
      end
    endcase

    out_d.kind  = kind;
    out_d.x     = to_field(pt.x);
    out_d.y     = to_field(pt.y);
    out_d.fill0 = job_i.fill0;
    out_d.fill1 = job_i.fill1;
    out_d.line  = job_i.line;
    out_d.last  = last;
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (go) begin
      out_vld_d = 1'b1;
    end else if (pt_o.ready) begin
      out_vld_d = 1'b0;
    end
    done_d = done_q;
    if (adv_o) begin
      done_d = '0;
    end else if (go) begin
      done_d = done_q | pick_oh;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      done_q    <= '0;
    end else begin
      out_vld_q <= out_vld_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      out_q <= out_d;
    end
  end

  assign pt_o.valid       = out_vld_q;
  assign pt_o.kind        = out_q.kind;
  assign pt_o.point_x     = out_q.x;
  assign pt_o.point_y     = out_q.y;
  assign pt_o.fill0_style = out_q.fill0;
  assign pt_o.fill1_style = out_q.fill1;
  assign pt_o.line_style  = out_q.line;
  assign pt_o.last        = out_q.last;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_i |-> (pend != '0))
    else $error("job at pipeline end owes no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_i && adv_o) |=> (out_vld_q && out_q.last))
    else $error("job retired without a final result");

endmodule

@@ rtl/shape_record_path_flattener.sv @@
// Shape record path flattener: records in, absolute path points out, one point per cycle
// while the point channel is ready. Each record yields 1 to 6 points (a curve 5 or 6),
// all through the single point channel; records yielding nothing never reach the back end.
// Reset (async, active low) clears pen, styles, open path, job queue and pipeline valids.
module shape_record_path_flattener (
  input  logic       clk_i,
  input  logic       rst_ni,
  srpf_rec_if.sink   rec_i,
  srpf_pt_if.source  pt_o
);
  import srpf_pkg::*;

  // Front end to queue
  logic q_push, q_full, q_valid, adv;
  job_t q_in_job, q_out_job;

  // Subdivision pipeline to emitter
  logic             sd_vld;
  job_t             sd_job;
  spt_t [NLEAF-1:0] sd_leaf;

  // The front end tracks pen and styles and turns every accepted record that owes a result
  // into a job. It stalls only when the queue is full, so a record is taken every cycle the
  // queue is not full, even while the back end is still draining earlier ones.
  srpf_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rec_i     (rec_i),
    .q_ready_i (!q_full),
    .q_push_o  (q_push),
    .q_job_o   (q_in_job)
  );

  // Hold jobs here so that front and back stall independently.
  srpf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in_job),
    .pop_i   (adv),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (q_out_job)
  );

  // Advance the whole pipeline whenever its last stage is empty or retiring; an empty
  // queue inserts a bubble. Curve leaves are ready when the job reaches the last stage.
  srpf_subdiv u_subdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (q_valid),
    .job_i  (q_out_job),
    .vld_o  (sd_vld),
    .job_o  (sd_job),
    .leaf_o (sd_leaf)
  );

  // Emit restyle, start, leaf and end points in order, one per cycle while pt_o is ready,
  // through an output register that keeps loading while the previous point is being taken.
  srpf_emit u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (sd_vld),
    .job_i  (sd_job),
    .leaf_i (sd_leaf),
    .adv_o  (adv),
    .pt_o   (pt_o)
  );

endmodule
